/* hw/rtl/sht_pkg.sv */
// Package for the server health tracker: sizes, codes, entry, config and result types.
// No dependencies; every other file of the block uses it.
package sht_pkg;

   localparam int ENTRIES   = 256;
   localparam int TIME_BITS = 40;
   localparam int CNT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ADDR_BITS = 5;

   localparam logic [16:0] FAIL_MAX = 17'h1FFFF;
   localparam logic [15:0] REC_MAX  = 16'hFFFF;
   localparam logic [7:0]  FLAP_MAX = 8'hFF;

   typedef enum logic [1:0] {
      CMD_CHECK = 2'd0,
      CMD_OK    = 2'd1,
      CMD_FAIL  = 2'd2,
      CMD_FORCE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_DOWN = 2'd1,
      EV_UP   = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      REG_FAIL_THRESHOLD = 3'd0,
      REG_RECOVERY_MIN   = 3'd1,
      REG_COOLDOWN_BASE  = 3'd2,
      REG_COOLDOWN_CAP   = 3'd3,
      REG_BACKOFF_MAX    = 3'd4,
      REG_FLAP_RESET     = 3'd5
   } reg_type;

   typedef struct packed {
      logic                 valid;
      logic [31:0]          id;
      logic [16:0]          failures;
      logic                 down;
      logic [15:0]          recovery;
      logic [TIME_BITS-1:0] cool_end;
      logic [7:0]           flaps;
      logic [TIME_BITS-1:0] since;
   } entry_type;

   typedef struct packed {
      logic [15:0] fail_limit;
      logic [15:0] recovery_min;
      logic [23:0] cooldown_base_ms;
      logic [23:0] cooldown_cap_ms;
      logic [3:0]  backoff_max;
      logic [23:0] flap_reset_ms;
   } cfg_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  event_res;
      logic        probe_due;
      logic        is_down;
      logic [16:0] failures;
      logic [23:0] cool_ms;
      logic [7:0]  flaps;
   } result_type;

endpackage

/* hw/rtl/sht_req_if.sv */
// Request and response channel interfaces of the server health tracker.
// Depends on sht_pkg for the time width.
interface sht_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [31:0]                   ds_id;
   logic [sht_pkg::TIME_BITS-1:0] now_ms;

   modport source (output valid, cmd, ds_id, now_ms, input ready);
   modport sink   (input valid, cmd, ds_id, now_ms, output ready);
endinterface

interface sht_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [1:0]  event_res;
   logic        probe_due;
   logic        is_down;
   logic [16:0] failures;
   logic [23:0] cool_ms;
   logic [7:0]  flaps;

   modport source (output valid, status, event_res, probe_due, is_down, failures,
                   cool_ms, flaps, input ready);
   modport sink   (input valid, status, event_res, probe_due, is_down, failures,
                   cool_ms, flaps, output ready);
endinterface

/* hw/rtl/sht_csr.sv */
// Configuration registers of the server health tracker, APB-style write and read.
// Depends on sht_pkg.
module sht_csr import sht_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;
   reg_type idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = reg_type'(paddr[4:2]);
   assign cfg    = cfg_ff;

   // Decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_FAIL_THRESHOLD: cfg_in.fail_limit       = pwdata[15:0];
            REG_RECOVERY_MIN:   cfg_in.recovery_min     = pwdata[15:0];
            REG_COOLDOWN_BASE:  cfg_in.cooldown_base_ms = pwdata[23:0];
            REG_COOLDOWN_CAP:   cfg_in.cooldown_cap_ms  = pwdata[23:0];
            REG_BACKOFF_MAX:    cfg_in.backoff_max      = pwdata[3:0];
            REG_FLAP_RESET:     cfg_in.flap_reset_ms    = pwdata[23:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fail_limit       <= 16'd6;
         cfg_ff.recovery_min     <= 16'd3;
         cfg_ff.cooldown_base_ms <= 24'd30000;
         cfg_ff.cooldown_cap_ms  <= 24'd480000;
         cfg_ff.backoff_max      <= 4'd4;
         cfg_ff.flap_reset_ms    <= 24'd60000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (idx)
         REG_FAIL_THRESHOLD: prdata = {16'd0, cfg_ff.fail_limit};
         REG_RECOVERY_MIN:   prdata = {16'd0, cfg_ff.recovery_min};
         REG_COOLDOWN_BASE:  prdata = {8'd0, cfg_ff.cooldown_base_ms};
         REG_COOLDOWN_CAP:   prdata = {8'd0, cfg_ff.cooldown_cap_ms};
         REG_BACKOFF_MAX:    prdata = {28'd0, cfg_ff.backoff_max};
         REG_FLAP_RESET:     prdata = {8'd0, cfg_ff.flap_reset_ms};
         default:            prdata = 32'd0;
      endcase
   end

endmodule

/* hw/rtl/sht_cell.sv */
// One table cell: holds a single server entry and takes its neighbor's entry on shift.
// Depends on sht_pkg.
module sht_cell import sht_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type ent_d,
   output entry_type ent_q
);

   entry_type ent_ff;

   assign ent_q = ent_ff;

   // Valid flag clears on reset, payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else if (shift) begin
         ent_ff <= ent_d;
      end
   end

endmodule

/* hw/rtl/sht_update.sv */
// Head-of-chain update: applies one event to the matching entry and forms the result.
// Depends on sht_pkg.
module sht_update import sht_pkg::*; (
   input  cfg_type              cfg,
   input  cmd_type              cmd,
   input  logic [TIME_BITS-1:0] now,
   input  entry_type            ent_in,
   output entry_type            ent_out,
   output result_type           res
);

   logic [15:0]          rthr;
   logic [15:0]          rec_inc;
   logic [17:0]          fsum;
   logic [16:0]          fsat;
   logic [16:0]          inc;
   logic [3:0]           expo;
   logic [38:0]          cd_raw;
   logic [23:0]          cd;
   logic [TIME_BITS:0]   until_sum;
   logic [TIME_BITS-1:0] elapsed;
   logic                 trip;

   // Shared arithmetic for the event
   always_comb begin
      rthr    = ((cfg.fail_limit >> 1) < cfg.recovery_min) ? cfg.recovery_min
                                                          : (cfg.fail_limit >> 1);
      rec_inc = (ent_in.recovery == REC_MAX) ? REC_MAX : ent_in.recovery + 16'd1;
      inc     = (cmd == CMD_FORCE) ? {1'b0, cfg.fail_limit} : 17'd1;
      fsum    = {1'b0, ent_in.failures} + {1'b0, inc};
      fsat    = fsum[17] ? FAIL_MAX : fsum[16:0];
      trip    = {1'b0, fsat} >= {2'b00, cfg.fail_limit};
      expo    = (ent_in.flaps < {4'd0, cfg.backoff_max}) ? ent_in.flaps[3:0]
                                                         : cfg.backoff_max;
      cd_raw  = {15'd0, cfg.cooldown_base_ms} << expo;
      cd      = (cd_raw > {15'd0, cfg.cooldown_cap_ms}) ? cfg.cooldown_cap_ms
                                                        : cd_raw[23:0];
      until_sum = {1'b0, now} + {{(TIME_BITS-23){1'b0}}, cd};
      elapsed = now - ent_in.since;
   end

   // Apply the command
   always_comb begin
      ent_out = ent_in;
      res     = '0;
      unique case (cmd)
         CMD_CHECK: begin
            res.probe_due = !(ent_in.down && (ent_in.cool_end > now));
         end
         CMD_OK: begin
            ent_out.failures = '0;
            if (ent_in.down) begin
               if (rec_inc >= rthr) begin
                  ent_out.recovery = '0;
                  ent_out.since    = now;
                  ent_out.down     = 1'b0;
                  res.event_res    = EV_UP;
               end else begin
                  ent_out.recovery = rec_inc;
               end
            end else if ((ent_in.flaps != 8'd0) && (ent_in.since != '0) &&
                         (elapsed > {{(TIME_BITS-24){1'b0}}, cfg.flap_reset_ms})) begin
               ent_out.flaps = '0;
            end
         end
         CMD_FAIL, CMD_FORCE: begin
            ent_out.recovery = '0;
            if ((cmd == CMD_FORCE) || !ent_in.down) begin
               ent_out.down = 1'b0;
               if (trip) begin
                  ent_out.failures = '0;
                  ent_out.cool_end = until_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
                                                          : until_sum[TIME_BITS-1:0];
                  ent_out.flaps    = (ent_in.flaps == FLAP_MAX) ? FLAP_MAX
                                                                : ent_in.flaps + 8'd1;
                  ent_out.down     = 1'b1;
                  res.event_res    = EV_DOWN;
                  res.cool_ms      = cd;
               end else begin
                  ent_out.failures = fsat;
               end
            end
         end
         default: ent_out = ent_in;
      endcase
      res.is_down  = ent_out.down;
      res.failures = ent_out.failures;
      res.flaps    = ent_out.flaps;
   end

endmodule

/* hw/rtl/server_health_tracker.sv */
// Server health tracker top level: request/response channels, APB-style config port.
// Depends on sht_pkg, sht_req_if, sht_rsp_if, sht_csr, sht_cell and sht_update.
//
// The entry table is a chain of ENTRIES cells that rotates one place per cycle
// through an update stage at its head, holding at the last place while the
// previous response is still unaccepted. Each request takes one full rotation;
// the result then waits in an output register, and a new request is taken once
// the rotation is done. Ids are matched against valid entries as they pass the
// head; slots fill in order, so the first empty cell met is where an unseen id
// is placed; with no match and no empty cell, the response reports a full table.
module server_health_tracker import sht_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   sht_req_if.sink              req_if,
   sht_rsp_if.source            rsp_if,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   cfg_type              cfg;
   entry_type            cell_q [ENTRIES];
   entry_type            head, upd_in, upd_out, feed, fresh;
   result_type           upd_res, pend_ff, out_ff, full_res;
   logic                 busy_ff, found_ff, out_valid_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   cmd_type              cmd_ff;
   logic [31:0]          id_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 last, fin_ok, shift, hit, take;

   sht_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   // Head of the chain and the entry handed back to its tail
   assign head   = cell_q[0];
   assign hit    = !found_ff && head.valid && (head.id == id_ff);
   assign take   = !found_ff && (hit || !head.valid);
   always_comb begin
      fresh       = '0;
      fresh.valid = 1'b1;
      fresh.id    = id_ff;
   end
   assign upd_in = head.valid ? head : fresh;
   assign feed   = take ? upd_out : head;

   sht_update u_update (
      .cfg(cfg), .cmd(cmd_ff), .now(now_ff), .ent_in(upd_in),
      .ent_out(upd_out), .res(upd_res)
   );

   // Row of cells, each takes its right neighbor's entry
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == ENTRIES - 1) begin : g_tail
         sht_cell u_cell (.clock(clock), .reset(reset), .shift(shift),
                          .ent_d(feed), .ent_q(cell_q[i]));
      end else begin : g_body
         sht_cell u_cell (.clock(clock), .reset(reset), .shift(shift),
                          .ent_d(cell_q[i+1]), .ent_q(cell_q[i]));
      end
   end

   assign last   = (cnt_ff == CNT_BITS'(ENTRIES - 1));
   assign fin_ok = !out_valid_ff || rsp_if.ready;
   assign shift  = busy_ff && (!last || fin_ok);

   always_comb begin
      full_res        = '0;
      full_res.status = 1'b1;
   end

   assign req_if.ready = !busy_ff;

   // Sequence control: accept, rotate, finish
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (shift && last) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (req_if.valid && !busy_ff) begin
            busy_ff  <= 1'b1;
            found_ff <= 1'b0;
            cnt_ff   <= '0;
         end else if (shift) begin
            cnt_ff <= cnt_ff + CNT_BITS'(1);
            if (take) begin
               found_ff <= 1'b1;
            end
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_if.valid && !busy_ff) begin
         cmd_ff <= cmd_type'(req_if.cmd);
         id_ff  <= req_if.ds_id;
         now_ff <= req_if.now_ms;
      end
      if (shift && take) begin
         pend_ff <= upd_res;
      end
      if (shift && last) begin
         out_ff <= take ? upd_res : (found_ff ? pend_ff : full_res);
      end
   end

   // Drive the response transfer
   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.status    = out_ff.status;
   assign rsp_if.event_res = out_ff.event_res;
   assign rsp_if.probe_due = out_ff.probe_due;
   assign rsp_if.is_down   = out_ff.is_down;
   assign rsp_if.failures  = out_ff.failures;
   assign rsp_if.cool_ms   = out_ff.cool_ms;
   assign rsp_if.flaps     = out_ff.flaps;

endmodule

/* verif/server_health_tracker_test.sv */
// Self-checking testbench for the server health tracker: drives health events, rewrites
// the config registers between phases and checks every response against its own predictor.
// Depends on sht_pkg, sht_req_if, sht_rsp_if and the server_health_tracker RTL.
module server_health_tracker_test;
   import sht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE      = 300;
   localparam int POOL_SIZE   = 32;
   localparam logic [TIME_BITS-1:0] TIME_TOP = {TIME_BITS{1'b1}};

   // Shadow of the entry table and the registers, plus the queue of expected responses
   class health_scoreboard;
      logic [15:0] thr, rmin;
      logic [23:0] base, cap, frst;
      logic [3:0]  bmax;
      bit                   used [ENTRIES];
      logic [31:0]          ids [ENTRIES];
      logic [16:0]          fails [ENTRIES];
      bit                   down [ENTRIES];
      logic [15:0]          recov [ENTRIES];
      logic [TIME_BITS-1:0] cool_end [ENTRIES];
      logic [7:0]           flaps [ENTRIES];
      logic [TIME_BITS-1:0] since [ENTRIES];
      result_type expected_q [$];
      int errors, n_items, n_down, n_up, n_full, n_slots;

      function new();
         thr = 6; rmin = 3; base = 30000; cap = 480000; bmax = 4; frst = 60000;
         foreach (used[i]) used[i] = 0;
      endfunction

      function void write_reg(reg_type r, logic [31:0] value);
         case (r)
            REG_FAIL_THRESHOLD: thr  = value[15:0];
            REG_RECOVERY_MIN:   rmin = value[15:0];
            REG_COOLDOWN_BASE:  base = value[23:0];
            REG_COOLDOWN_CAP:   cap  = value[23:0];
            REG_BACKOFF_MAX:    bmax = value[3:0];
            REG_FLAP_RESET:     frst = value[23:0];
            default: ;
         endcase
      endfunction

      // Find the slot of an id, claiming the lowest free one on first sight
      function int find_slot(logic [31:0] id);
         for (int i = 0; i < ENTRIES; i++)
            if (used[i] && ids[i] == id) return i;
         for (int i = 0; i < ENTRIES; i++)
            if (!used[i]) begin
               used[i] = 1; ids[i] = id; fails[i] = 0; down[i] = 0; recov[i] = 0;
               cool_end[i] = 0; flaps[i] = 0; since[i] = 0;
               n_slots++;
               return i;
            end
         return -1;
      endfunction

      // Add failures to an online server; returns 1 when it goes offline
      function bit add_failures(int s, logic [15:0] inc, logic [TIME_BITS-1:0] now,
                                output logic [63:0] cd);
         logic [17:0] f;
         logic [3:0]  e;
         logic [63:0] end_t;
         recov[s] = 0;
         f = 18'(fails[s]) + 18'(inc);
         if (f > FAIL_MAX) f = FAIL_MAX;
         fails[s] = f[16:0];
         cd = 0;
         if (f < thr) return 0;
         e = (flaps[s] < bmax) ? flaps[s][3:0] : bmax;
         cd = 64'(base) << e;
         if (cd > cap) cd = 64'(cap);
         end_t = 64'(now) + cd;
         if (end_t > 64'(TIME_TOP)) end_t = 64'(TIME_TOP);
         fails[s] = 0;
         cool_end[s] = end_t[TIME_BITS-1:0];
         if (flaps[s] != FLAP_MAX) flaps[s]++;
         down[s] = 1;
         return 1;
      endfunction

      // Predict the response to an accepted event
      function void note_request(logic [1:0] cmd, logic [31:0] id, logic [TIME_BITS-1:0] now);
         result_type r;
         int s;
         logic [63:0] cd;
         logic [15:0] rthr;
         logic [TIME_BITS-1:0] elapsed;
         bit fired;
         r = '0;
         n_items++;
         s = find_slot(id);
         if (s < 0) begin
            r.status = 1'b1;
            n_full++;
         end else begin
            case (cmd)
               CMD_CHECK: r.probe_due = !(down[s] && cool_end[s] > now);
               CMD_OK: begin
                  fails[s] = 0;
                  if (down[s]) begin
                     rthr = thr >> 1;
                     if (rthr < rmin) rthr = rmin;
                     if (recov[s] != REC_MAX) recov[s]++;
                     if (recov[s] >= rthr) begin
                        recov[s] = 0; since[s] = now; down[s] = 0;
                        r.event_res = EV_UP;
                        n_up++;
                     end
                  end else begin
                     elapsed = now - since[s];
                     if (flaps[s] != 0 && since[s] != 0 && elapsed > frst) flaps[s] = 0;
                  end
               end
               default: begin
                  fired = 0;
                  if (cmd == CMD_FORCE) begin
                     down[s] = 0;
                     fired = add_failures(s, thr, now, cd);
                  end else if (down[s]) begin
                     recov[s] = 0;
                  end else begin
                     fired = add_failures(s, 16'd1, now, cd);
                  end
                  if (fired) begin
                     r.event_res = EV_DOWN;
                     r.cool_ms   = cd[23:0];
                     n_down++;
                  end
               end
            endcase
            r.is_down  = down[s];
            r.failures = fails[s];
            r.flaps    = flaps[s];
         end
         expected_q.push_back(r);
      endfunction

      function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare a response with the oldest prediction
      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected, actual %p", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         report_field("status",    32'(want.status),    32'(got.status));
         report_field("event_res", 32'(want.event_res), 32'(got.event_res));
         report_field("probe_due", 32'(want.probe_due), 32'(got.probe_due));
         report_field("is_down",   32'(want.is_down),   32'(got.is_down));
         report_field("failures",  32'(want.failures),  32'(got.failures));
         report_field("cool_ms",   32'(want.cool_ms),   32'(got.cool_ms));
         report_field("flaps",     32'(want.flaps),     32'(got.flaps));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sht_req_if req_bus ();
   sht_rsp_if rsp_bus ();

   health_scoreboard sb = new();
   logic [TIME_BITS-1:0] now_t = 1000;
   logic [31:0] id_pool [POOL_SIZE];
   bit quiet = 0;
   int hold_cycles = 0;
   int idle_count = 0;

   server_health_tracker dut (
      .clock(clock), .reset(reset), .req_if(req_bus), .rsp_if(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_bus.valid  = 0;
      req_bus.cmd    = CMD_CHECK;
      req_bus.ds_id  = '0;
      req_bus.now_ms = '0;
      rsp_bus.ready  = 0;
   end

   // Gap length: mostly none, sometimes short, rarely long
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // Response side: random stalls, plus the long hold-off when requested
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_result('{rsp_bus.status, rsp_bus.event_res, rsp_bus.probe_due,
                              rsp_bus.is_down, rsp_bus.failures, rsp_bus.cool_ms,
                              rsp_bus.flaps});
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 0;
         end else begin
            stall_left = pick_gap();
            rsp_bus.ready <= (stall_left == 0);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_count <= 0;
      else if (!reset)
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // Send one event and hold it until the transfer
   task automatic send(logic [1:0] cmd, logic [31:0] id, logic [TIME_BITS-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1;
      req_bus.cmd    <= cmd;
      req_bus.ds_id  <= id;
      req_bus.now_ms <= now;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(cmd, id, now);
   endtask

   task automatic advance_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) now_t += TIME_BITS'($urandom_range(0, 4000));
      else if (r < 93) now_t += TIME_BITS'($urandom_range(0, 600000));
      else if (r < 97) now_t = TIME_BITS'({$urandom(), $urandom()});
      else now_t -= TIME_BITS'($urandom_range(0, 5000));
   endtask

   task automatic send_now(logic [1:0] cmd, logic [31:0] id);
      advance_time();
      send(cmd, id, now_t);
   endtask

   // Drain the block so registers may be rewritten
   task automatic wait_idle();
      if (req_bus.valid) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write: setup phase, access phase until pready, then back to idle
   task automatic csr_write(reg_type r, logic [31:0] value);
      logic [31:0] word;
      word = $urandom();
      word = (r == REG_BACKOFF_MAX) ? {word[31:4], value[3:0]} :
             (r <= REG_RECOVERY_MIN) ? {word[31:16], value[15:0]} :
             {word[31:24], value[23:0]};
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= ADDR_BITS'(4 * int'(r));
      pwdata  <= word;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      sb.write_reg(r, word);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic load_config(logic [15:0] thr, logic [15:0] rmin, logic [23:0] base,
                              logic [23:0] cap, logic [3:0] bmax, logic [23:0] frst);
      wait_idle();
      csr_write(REG_FAIL_THRESHOLD, thr);
      csr_write(REG_RECOVERY_MIN, rmin);
      csr_write(REG_COOLDOWN_BASE, base);
      csr_write(REG_COOLDOWN_CAP, cap);
      csr_write(REG_BACKOFF_MAX, bmax);
      csr_write(REG_FLAP_RESET, frst);
   endtask

   // One outage episode on a server, with random noise mixed in
   task automatic episode();
      logic [31:0] id;
      int n;
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      n = $urandom_range(0, 8);
      repeat (n) send_now($urandom_range(0, 9) == 0 ? CMD_OK : CMD_FAIL, id);
      if ($urandom_range(0, 3) == 0) send_now(CMD_FORCE, id);
      send_now(CMD_CHECK, id);
      n = $urandom_range(0, 6);
      repeat (n) send_now($urandom_range(0, 7) == 0 ? CMD_FAIL : CMD_OK, id);
      send_now(CMD_CHECK, id);
   endtask

   task automatic random_mix(int count);
      int start;
      start = sb.n_items;
      while (sb.n_items - start < count) begin
         if ($urandom_range(0, 99) < 75) episode();
         else if ($urandom_range(0, 1) == 0) send_now(2'($urandom_range(0, 3)), $urandom());
         else send_now(2'($urandom_range(0, 3)), id_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end
   endtask

   initial begin
      logic [31:0] flap_id;
      foreach (id_pool[i]) id_pool[i] = $urandom();
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset config, all commands, cooldown, recovery, flap clear, edges of time
      send(CMD_CHECK, 32'h0, 40'd0);
      send(CMD_CHECK, 32'hFFFF_FFFF, TIME_TOP);
      repeat (6) send(CMD_FAIL, 32'h0, 40'd100);
      send(CMD_CHECK, 32'h0, 40'd200);
      send(CMD_FAIL, 32'h0, 40'd300);
      send(CMD_CHECK, 32'h0, 40'd30100);
      repeat (3) send(CMD_OK, 32'h0, 40'd40000);
      send(CMD_OK, 32'h0, 40'd100001);
      send(CMD_FORCE, 32'h0, 40'd100002);
      send(CMD_FORCE, 32'h0, 40'd100003);
      send(CMD_FORCE, 32'hFFFF_FFFF, TIME_TOP - 40'd5);
      send(CMD_CHECK, 32'hFFFF_FFFF, TIME_TOP);
      repeat (3) send(CMD_OK, 32'hFFFF_FFFF, 40'd7);
      send(CMD_OK, 32'hFFFF_FFFF, 40'd3);

      // Zero threshold, widest cooldown range, flap reset of zero
      load_config(16'd0, 16'd1, 24'd1, 24'hFF_FFFF, 4'd15, 24'd0);
      random_mix(250);

      // Zero cap, single-failure threshold; then drive one server's flaps to saturation
      load_config(16'd1, 16'd2, 24'hFF_FFFF, 24'd0, 4'd0, 24'hFF_FFFF);
      random_mix(150);
      flap_id = $urandom();
      quiet = 1;
      repeat (260) send_now(CMD_FORCE, flap_id);
      send_now(CMD_CHECK, flap_id);
      quiet = 0;

      // Largest threshold and recovery bound; long response hold-off while requests queue
      load_config(16'hFFFF, 16'hFFFF, 24'd1000, 24'd100000, 4'd7, 24'd5000);
      random_mix(60);
      hold_cycles = 1500;
      random_mix(90);

      // Small thresholds, no idling, then fill the table and go past it
      load_config(16'd3, 16'd2, 24'd500, 24'd20000, 4'd4, 24'd3000);
      quiet = 1;
      random_mix(150);
      quiet = 0;
      random_mix(100);
      while (sb.n_slots < ENTRIES) send_now(2'($urandom_range(0, 3)), $urandom());
      random_mix(40);
      repeat (10) send_now(2'($urandom_range(0, 3)), $urandom());

      wait_idle();
      $display("Covered %0d events over %0d servers: %0d outages, %0d recoveries,",
               sb.n_items, sb.n_slots, sb.n_down, sb.n_up);
      $display("%0d table-full responses, five register sets incl. zero threshold and cap.",
               sb.n_full);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* server_health_tracker.f */
hw/rtl/sht_pkg.sv
hw/rtl/sht_req_if.sv
hw/rtl/sht_csr.sv
hw/rtl/sht_cell.sv
hw/rtl/sht_update.sv
hw/rtl/server_health_tracker.sv
verif/server_health_tracker_test.sv
